// ----- rtl/core/cseg_pkg.sv -----
// ----------------------------------------------------------------------------
// cseg_pkg
// Shared types, opcodes, status codes and helper functions of the 16-bit core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cseg_pkg;

  localparam int MEM_ADDR_BITS_DEF = 21;

  // run status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_SEGF  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // special register indexes
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_PC   = 5'd15;
  localparam logic [4:0] REG_FL   = 5'd20;
  localparam logic [4:0] REG_RA   = 5'd24;
  localparam logic [4:0] REG_SP   = 5'd25;
  localparam logic [4:0] REG_SEGX = 5'd29;
  localparam logic [4:0] REG_SEGV = 5'd30;

  localparam logic [32:0] IO_PORT = 33'h130000;
  localparam logic [16:0] IO_SEG  = 17'h13;

  localparam logic [7:0] SEG_CODE  = 8'h04;
  localparam logic [7:0] SEG_STACK = 8'h12;
  localparam logic [7:0] SEG_DATA  = 8'h11;
  localparam logic [7:0] SEG_IO    = 8'h13;
  localparam logic [7:0] SEG_NONE  = 8'h00;

  typedef enum logic [4:0] {
    OP_NOP  = 5'd0,  OP_MOV  = 5'd1,  OP_ADD  = 5'd2,  OP_SUB  = 5'd3,
    OP_OR   = 5'd4,  OP_AND  = 5'd5,  OP_NOT  = 5'd6,  OP_ADDI = 5'd7,
    OP_SUBI = 5'd8,  OP_ORI  = 5'd9,  OP_ANDI = 5'd10, OP_SL   = 5'd11,
    OP_SR   = 5'd12, OP_SRA  = 5'd13, OP_LDW  = 5'd14, OP_STW  = 5'd15,
    OP_JMP  = 5'd16, OP_JZ   = 5'd17, OP_JC   = 5'd18, OP_JNZ  = 5'd19,
    OP_JNC  = 5'd20, OP_JAL  = 5'd21, OP_JR   = 5'd22, OP_LDB  = 5'd24,
    OP_STB  = 5'd25, OP_HALT = 5'd31
  } opcode_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_OR, ALU_AND, ALU_NOT, ALU_SL, ALU_SR, ALU_SRA
  } alu_t;

  typedef enum logic {KIND_HOST, KIND_STEP} kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] addr;
    logic [15:0] data;
    logic [7:0]  rx;
  } item_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_F1, S_DEC, S_EXE, S_SEG, S_WB
  } bstate_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] seg;
  } seg_t;

  // segment base by the base register index; r29 takes its base from r30
  function automatic seg_t seg_lookup(input logic [4:0] r);
    seg_t s;
    s.ok  = 1'b1;
    s.seg = SEG_NONE;
    if (r < 5'd8) begin
      s.seg = SEG_CODE;
    end else begin
      unique case (r)
        5'd23, REG_SP: s.seg = SEG_STACK;
        5'd26:         s.seg = SEG_DATA;
        5'd27:         s.seg = SEG_CODE;
        5'd28:         s.seg = SEG_IO;
        REG_SEGX:      s.seg = SEG_NONE;
        5'd31:         s.seg = SEG_NONE;
        default:       s.ok  = 1'b0;
      endcase
    end
    return s;
  endfunction

  // returns {carry, result}
  function automatic logic [16:0] alu_calc(input alu_t f, input logic [15:0] x,
                                           input logic [15:0] y);
    logic [16:0] s;
    logic [31:0] w;
    logic [3:0]  sh;
    logic [15:0] r;
    logic        cy;
    s  = '0;
    w  = '0;
    sh = '0;
    r  = '0;
    cy = 1'b0;
    unique case (f)
      ALU_ADD: begin
        s  = {1'b0, x} + {1'b0, y};
        r  = s[15:0];
        cy = s[16];
      end
      ALU_SUB: begin
        r  = x - y;
        cy = (x >= y);
      end
      ALU_OR:  r = x | y;
      ALU_AND: r = x & y;
      ALU_NOT: r = ~x;
      ALU_SL: begin
        if (y <= 16'd16) begin
          w  = {16'h0, x} << y[4:0];
          r  = w[15:0];
          cy = w[16];
        end
      end
      ALU_SR: begin
        if (y <= 16'd15) r = x >> y[3:0];
        cy = x[0];
      end
      ALU_SRA: begin
        sh = (y > 16'd15) ? 4'd15 : y[3:0];
        r  = 16'($signed(x) >>> sh);
        cy = x[0];
      end
      default: r = '0;
    endcase
    return {cy, r};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cseg_front.sv -----
// ----------------------------------------------------------------------------
// cseg_front
// Input side: accepts items, tags them host or step, and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cseg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 enable,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [19:0]          in_host_word_addr,
  input  logic [15:0]          in_host_word_data,
  input  logic [7:0]           in_rx_byte,
  output logic                 head_valid,
  output cseg_pkg::item_t      head,
  input  logic                 pop
);
  import cseg_pkg::*;

  item_t       q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       new_item;

  assign in_ready   = (cnt_r != 2'd2) && enable;
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    new_item.kind = in_req_type ? KIND_STEP : KIND_HOST;
    new_item.addr = in_host_word_addr;
    new_item.data = in_host_word_data;
    new_item.rx   = in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cseg_exec.sv -----
// ----------------------------------------------------------------------------
// cseg_exec
// Back end: instruction sequencer, register file, main memory, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cseg_exec #(
  parameter int MEM_ADDR_BITS = cseg_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 ready_for_items,
  input  logic                 head_valid,
  input  cseg_pkg::item_t      head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_run_status,
  output logic [15:0]          out_program_counter,
  output logic [1:0]           out_flag_bits,
  output logic                 out_tx_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_rx_used
);
  import cseg_pkg::*;

  localparam int AW = MEM_ADDR_BITS - 1;

  bstate_t     state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [15:0] lo_r, hi_r, pc_r, pc_nxt, fl_r, fl_nxt, rbv_r, rbv_nxt;
  logic [1:0]  stop_r, stop_nxt;
  logic [AW-1:0] acc_addr_r, acc_addr_nxt;
  logic        acc_io_r, acc_io_nxt, acc_hit_r, acc_hit_nxt, acc_odd_r, acc_odd_nxt;

  // register file
  logic [15:0] rf [32];
  logic [31:0] rf_vld_r;
  logic [15:0] rfa_q, rfb_q;
  logic        rfa_v_r, rfb_v_r;
  logic [4:0]  rfa_addr_r, rfb_addr_r, rfa_sel, rfb_sel;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [15:0] rf_wd;
  logic        rf_arr_we;

  // main memory
  logic [15:0]   mem [2**AW];
  logic [15:0]   mem_q, mem_wd;
  logic [AW-1:0] mem_a;
  logic          mem_we;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_pc_r;
  logic [1:0]  out_fl_r;
  logic        out_txv_r, out_rxu_r;
  logic [7:0]  out_txb_r;

  logic        go, fin, commit, txv, rxu;
  logic [7:0]  txb;
  logic [15:0] hi_cur, imm, va, vb, bv, segval, alu_y, ld_val;
  logic [4:0]  op, ra, rb, rc;
  logic        mem_op, word_op;
  alu_t        alu_f;
  logic [16:0] alu_out;
  seg_t        seg;
  logic [32:0] addr_calc;

  function automatic logic [15:0] rf_value(input logic [4:0] a, input logic [15:0] q,
                                           input logic v, input logic [15:0] pc,
                                           input logic [15:0] fl);
    logic [15:0] r;
    if (a == REG_ZERO)    r = '0;
    else if (a == REG_PC) r = pc;
    else if (a == REG_FL) r = fl;
    else if (v)           r = q;
    else if (a == REG_SP) r = 16'hFFFF;
    else                  r = '0;
    return r;
  endfunction

  assign ready_for_items = (state_r != S_CLR);
  assign go = !out_valid_r || out_ready;

  assign hi_cur  = (state_r == S_DEC) ? mem_q : hi_r;
  assign op      = hi_cur[15:11];
  assign ra      = hi_cur[9:5];
  assign rb      = hi_cur[4:0];
  assign rc      = lo_r[15:11];
  assign imm     = lo_r;
  assign mem_op  = (op == OP_LDW) || (op == OP_STW) || (op == OP_LDB) || (op == OP_STB);
  assign word_op = (op == OP_LDW) || (op == OP_STW);
  // r30 is read while the r29-based access moves on to the segment cycle
  assign rfa_sel = ((state_r == S_EXE && mem_op && rb == REG_SEGX) || state_r == S_SEG) ?
                   REG_SEGV : rb;
  assign rfb_sel = (mem_op || (op == OP_JR)) ? ra : rc;

  assign va = rf_value(rfa_addr_r, rfa_q, rfa_v_r, pc_r, fl_r);
  assign vb = rf_value(rfb_addr_r, rfb_q, rfb_v_r, pc_r, fl_r);
  assign bv = (state_r == S_SEG) ? rbv_r : va;

  assign seg       = seg_lookup(rb);
  assign segval    = (state_r == S_SEG) ? va : {8'h00, seg.seg};
  assign addr_calc = 33'({segval, 16'h0000}) + 33'(bv) + 33'(imm);

  always_comb begin
    alu_f = ALU_ADD;
    alu_y = vb;
    unique case (op)
      OP_ADD:  alu_f = ALU_ADD;
      OP_SUB:  alu_f = ALU_SUB;
      OP_OR:   alu_f = ALU_OR;
      OP_AND:  alu_f = ALU_AND;
      OP_NOT:  alu_f = ALU_NOT;
      OP_ADDI: begin alu_f = ALU_ADD; alu_y = imm; end
      OP_SUBI: begin alu_f = ALU_SUB; alu_y = imm; end
      OP_ORI:  begin alu_f = ALU_OR;  alu_y = imm; end
      OP_ANDI: begin alu_f = ALU_AND; alu_y = imm; end
      OP_SL:   alu_f = ALU_SL;
      OP_SR:   alu_f = ALU_SR;
      OP_SRA:  alu_f = ALU_SRA;
      default: alu_f = ALU_ADD;
    endcase
    alu_out = alu_calc(alu_f, bv, alu_y);
  end

  always_comb begin
    if (acc_io_r)          ld_val = acc_hit_r ? {8'h00, head.rx} : 16'h0000;
    else if (op == OP_LDW) ld_val = mem_q;
    else if (acc_odd_r)    ld_val = {8'h00, mem_q[15:8]};
    else                   ld_val = {8'h00, mem_q[7:0]};
  end

  always_comb begin
    state_nxt    = state_r;
    fin          = 1'b0;
    mem_we       = 1'b0;
    mem_a        = AW'({pc_r, 1'b0});
    mem_wd       = vb;
    rf_we        = 1'b0;
    rf_wa        = ra;
    rf_wd        = bv;
    pc_nxt       = pc_r;
    fl_nxt       = fl_r;
    stop_nxt     = stop_r;
    rbv_nxt      = rbv_r;
    acc_addr_nxt = acc_addr_r;
    acc_io_nxt   = acc_io_r;
    acc_hit_nxt  = acc_hit_r;
    acc_odd_nxt  = acc_odd_r;
    txv          = 1'b0;
    txb          = 8'h00;
    rxu          = 1'b0;

    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_a  = clr_cnt_r;
        mem_wd = 16'hFFFF;
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid) begin
          if (head.kind == KIND_HOST) begin
            fin    = 1'b1;
            mem_we = 1'b1;
            mem_a  = AW'(head.addr);
            mem_wd = head.data;
          end else if (stop_r != ST_RUN) begin
            fin = 1'b1;
          end else begin
            state_nxt = S_F1;
          end
        end
      end
      S_F1: begin
        mem_a     = AW'({pc_r, 1'b1});
        state_nxt = S_DEC;
      end
      S_DEC: begin
        pc_nxt    = pc_r + 16'd1;
        state_nxt = S_EXE;
      end
      S_EXE, S_SEG: begin
        unique case (op)
          OP_MOV: begin
            fin   = 1'b1;
            rf_we = 1'b1;
          end
          OP_ADD, OP_SUB, OP_OR, OP_AND, OP_NOT, OP_ADDI, OP_SUBI, OP_ORI, OP_ANDI,
          OP_SL, OP_SR, OP_SRA: begin
            fin    = 1'b1;
            fl_nxt = {14'h0, alu_out[16], (alu_out[15:0] == 16'h0000)};
            rf_we  = 1'b1;
            rf_wd  = alu_out[15:0];
          end
          OP_LDW, OP_STW, OP_LDB, OP_STB: begin
            acc_addr_nxt = addr_calc[MEM_ADDR_BITS-1:1];
            acc_io_nxt   = (addr_calc[32:16] == IO_SEG);
            acc_hit_nxt  = (addr_calc == IO_PORT);
            acc_odd_nxt  = addr_calc[0];
            mem_a        = addr_calc[MEM_ADDR_BITS-1:1];
            if (state_r == S_EXE && rb == REG_SEGX) begin
              // base comes from r30, read in the segment state
              rbv_nxt   = va;
              state_nxt = S_SEG;
            end else if (!seg.ok || (word_op && segval == 16'h0000)) begin
              fin      = 1'b1;
              stop_nxt = ST_SEGF;
            end else if (|(addr_calc >> MEM_ADDR_BITS)) begin
              fin      = 1'b1;
              stop_nxt = ST_RANGE;
            end else if (op == OP_STW) begin
              fin    = 1'b1;
              mem_we = 1'b1;
              if (addr_calc == IO_PORT) begin
                txv = 1'b1;
                txb = vb[7:0];
              end
            end else begin
              state_nxt = S_WB;
            end
          end
          OP_JMP: begin fin = 1'b1; pc_nxt = imm; end
          OP_JZ:  begin fin = 1'b1; if (fl_r[0])  pc_nxt = imm; end
          OP_JC:  begin fin = 1'b1; if (fl_r[1])  pc_nxt = imm; end
          OP_JNZ: begin fin = 1'b1; if (!fl_r[0]) pc_nxt = imm; end
          OP_JNC: begin fin = 1'b1; if (!fl_r[1]) pc_nxt = imm; end
          OP_JAL: begin
            fin    = 1'b1;
            rf_we  = 1'b1;
            rf_wa  = REG_RA;
            rf_wd  = pc_r;
            pc_nxt = imm;
          end
          OP_JR:   begin fin = 1'b1; pc_nxt = vb; end
          OP_HALT: begin fin = 1'b1; stop_nxt = ST_HALT; end
          default: fin = 1'b1;
        endcase
      end
      S_WB: begin
        fin   = 1'b1;
        mem_a = acc_addr_r;
        if (op == OP_STB) begin
          mem_we = 1'b1;
          mem_wd = acc_odd_r ? {vb[7:0], mem_q[7:0]} : {mem_q[15:8], vb[7:0]};
          if (acc_hit_r) begin
            txv = 1'b1;
            txb = vb[7:0];
          end
        end else begin
          rf_we = 1'b1;
          rf_wd = ld_val;
          rxu   = acc_hit_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register writes to the program counter and flags live in flops
    if (rf_we && rf_wa == REG_PC) pc_nxt = rf_wd;
    if (rf_we && rf_wa == REG_FL) fl_nxt = rf_wd;

    // a finished item waits here until the result register frees up
    if (fin && !go) begin
      mem_we    = 1'b0;
      rf_we     = 1'b0;
      pc_nxt    = pc_r;
      fl_nxt    = fl_r;
      stop_nxt  = stop_r;
      state_nxt = state_r;
    end else if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  assign commit    = fin && go;
  assign pop       = commit;
  assign rf_arr_we = rf_we && (rf_wa != REG_ZERO) && (rf_wa != REG_PC) && (rf_wa != REG_FL);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    mem_q <= mem[mem_a];
  end

  always_ff @(posedge clk) begin
    if (rf_arr_we) rf[rf_wa] <= rf_wd;
    rfa_q      <= rf[rfa_sel];
    rfb_q      <= rf[rfb_sel];
    rfa_v_r    <= rf_vld_r[rfa_sel];
    rfb_v_r    <= rf_vld_r[rfb_sel];
    rfa_addr_r <= rfa_sel;
    rfb_addr_r <= rfb_sel;
  end

  // lo half arrives in the cycle after its read in idle
  always_ff @(posedge clk) begin
    if (state_r == S_F1)  lo_r <= mem_q;
    if (state_r == S_DEC) hi_r <= mem_q;
    rbv_r      <= rbv_nxt;
    acc_addr_r <= acc_addr_nxt;
    acc_io_r   <= acc_io_nxt;
    acc_hit_r  <= acc_hit_nxt;
    acc_odd_r  <= acc_odd_nxt;
    if (commit) begin
      out_status_r <= stop_nxt;
      out_pc_r     <= pc_nxt;
      out_fl_r     <= fl_nxt[1:0];
      out_txv_r    <= txv;
      out_txb_r    <= txb;
      out_rxu_r    <= rxu;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      fl_r        <= '0;
      stop_r      <= ST_RUN;
      rf_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      pc_r   <= pc_nxt;
      fl_r   <= fl_nxt;
      stop_r <= stop_nxt;
      if (rf_arr_we) rf_vld_r[rf_wa] <= 1'b1;
      if (commit)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_run_status      = out_status_r;
  assign out_program_counter = out_pc_r;
  assign out_flag_bits       = out_fl_r;
  assign out_tx_valid        = out_txv_r;
  assign out_tx_byte         = out_txb_r;
  assign out_rx_used         = out_rxu_r;

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r != ST_RUN) |=> (stop_r != ST_RUN))
    else $error("stop code cleared without reset");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !pop)
    else $error("item retired during memory clear");

  a_fetch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F1 || state_r == S_DEC) |-> !mem_we)
    else $error("memory written during fetch");

  a_tx_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> !(txv && rxu))
    else $error("one item both sent and received a serial byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cpu16_segmented_core.sv -----
// ----------------------------------------------------------------------------
// cpu16_segmented_core
// 16-bit segmented processor with local memory: host word loads and steps.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid/in_ready, req, addr, data, rx  | input
//  out      | out_valid/out_ready, status, pc, flags, | output
//           | tx_valid, tx_byte, rx_used              |
//
// a host item is done in idle in the back end; a step passes idle, F1, DEC
// (two instruction-half reads and decode on the single memory port) and execute,
// plus write-back for loads and byte stores, plus the segment state when the
// base register is r29. after reset all 2**(MEM_ADDR_BITS-1) memory words are
// filled with 0xFFFF, during which in_ready stays low.
// a two-item queue lets the input side keep accepting while the back end or
// the output register stalls.
`timescale 1ns / 1ps
`default_nettype none

module cpu16_segmented_core #(
  parameter int MEM_ADDR_BITS = cseg_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [19:0] in_host_word_addr,
  input  logic [15:0] in_host_word_data,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_run_status,
  output logic [15:0] out_program_counter,
  output logic [1:0]  out_flag_bits,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_rx_used
);
  import cseg_pkg::*;

  item_t head;
  logic  head_valid, pop, enable;

  cseg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .enable            (enable),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_host_word_addr (in_host_word_addr),
    .in_host_word_data (in_host_word_data),
    .in_rx_byte        (in_rx_byte),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop)
  );

  cseg_exec #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_exec (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ready_for_items     (enable),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_run_status      (out_run_status),
    .out_program_counter (out_program_counter),
    .out_flag_bits       (out_flag_bits),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_rx_used         (out_rx_used)
  );

endmodule

`default_nettype wire

// ----- test/cpu16_segmented_core_test.sv -----
// ----------------------------------------------------------------------------
// cpu16_segmented_core_test
// Self-checking bench for the 16-bit segmented core. Instructions are loaded
// with host word writes and run one step at a time. An in-bench model of the
// core predicts every result, which is then compared field by field. Both
// handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu16_segmented_core_test;
  import cseg_pkg::*;

  localparam int          ADDR_BITS  = MEM_ADDR_BITS_DEF;
  localparam int unsigned WORD_MASK  = (1 << (ADDR_BITS - 1)) - 1;
  localparam longint      LIMIT      = 4_000_000;
  localparam int          N_RANDOM   = 1850;
  localparam logic [4:0]  OP_SPARE_A = 5'd23;
  localparam logic [4:0]  OP_SPARE_LO = 5'd26;
  localparam logic [4:0]  OP_SPARE_HI = 5'd30;
  localparam logic [4:0]  REG_DSEG   = 5'd26;
  localparam logic [4:0]  REG_IOB    = 5'd28;
  localparam logic [4:0]  REG_BSEG   = 5'd31;
  localparam logic [4:0]  REG_BAD    = 5'd10;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc;
    logic [1:0]  flags;
    logic        txv;
    logic [7:0]  txb;
    logic        rxu;
  } core_result_t;

  typedef struct {
    logic         req;
    logic [19:0]  addr;
    logic [15:0]  data;
    logic [7:0]   rx;
    bit           typed;
    core_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [19:0] in_host_word_addr;
  logic [15:0] in_host_word_data;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_run_status;
  logic [15:0] out_program_counter;
  logic [1:0]  out_flag_bits;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_rx_used;

  cpu16_segmented_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_host_word_addr(in_host_word_addr), .in_host_word_data(in_host_word_data),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_run_status(out_run_status),
    .out_program_counter(out_program_counter), .out_flag_bits(out_flag_bits),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte), .out_rx_used(out_rx_used)
  );

  // core model state
  logic [15:0] regs [32];
  logic [15:0] mem_img [int unsigned];
  logic [1:0]  halt_code;

  core_result_t pending_q [$];
  int     n_errors;
  int     n_steps, n_tx, n_rx, n_mem;
  longint cycles = 0;
  bit     send_burst, recv_burst;
  int     recv_stall;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] mem_rd(input int unsigned idx);
    idx = idx & WORD_MASK;
    return mem_img.exists(idx) ? mem_img[idx] : 16'hFFFF;
  endfunction

  function automatic logic [15:0] alu_eval(input alu_t f, input logic [15:0] x,
                                           input logic [15:0] y);
    logic [16:0] sum;
    logic [31:0] wide;
    logic [15:0] r;
    logic        cy;
    r  = '0;
    cy = 1'b0;
    case (f)
      ALU_ADD: begin
        sum = {1'b0, x} + {1'b0, y};
        r   = sum[15:0];
        cy  = sum[16];
      end
      ALU_SUB: begin
        r  = x - y;
        cy = (x >= y);
      end
      ALU_OR:  r = x | y;
      ALU_AND: r = x & y;
      ALU_NOT: r = ~x;
      ALU_SL: begin
        if (y <= 16) begin
          wide = {16'h0, x} << y;
          r    = wide[15:0];
          cy   = wide[16];
        end
      end
      ALU_SR: begin
        if (y <= 15) r = x >> y;
        cy = x[0];
      end
      default: begin
        r  = $signed(x) >>> ((y > 15) ? 15 : y);
        cy = x[0];
      end
    endcase
    regs[REG_FL] = {14'h0, cy, (r == 16'h0)};
    return r;
  endfunction

  // segment base for a base register, 0 when unlisted
  function automatic bit seg_base(input logic [4:0] rb, output logic [15:0] seg);
    seg = '0;
    if (rb < 8 || rb == 5'd27) seg = SEG_CODE;
    else if (rb == 5'd23 || rb == REG_SP) seg = SEG_STACK;
    else if (rb == REG_DSEG) seg = SEG_DATA;
    else if (rb == REG_IOB) seg = SEG_IO;
    else if (rb == REG_SEGX) seg = regs[REG_SEGV];
    else if (rb == REG_BSEG) seg = SEG_NONE;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic core_result_t core_next(input logic req, input logic [19:0] waddr,
                                             input logic [15:0] wdata, input logic [7:0] rx);
    core_result_t res;
    logic [15:0] lo, hi, imm, seg, v, rd;
    logic [4:0]  op, ra, rb, rc;
    longint      ea;
    int unsigned wi;
    bit          is_word, io, hit;
    res = '0;
    if (req == KIND_HOST) begin
      mem_img[waddr & WORD_MASK] = wdata;
    end else if (halt_code == ST_RUN) begin
      regs[0] = '0;
      lo  = mem_rd({regs[REG_PC], 1'b0});
      hi  = mem_rd({regs[REG_PC], 1'b0} + 1);
      regs[REG_PC] = regs[REG_PC] + 1;
      op  = hi[15:11];
      ra  = hi[9:5];
      rb  = hi[4:0];
      rc  = lo[15:11];
      imm = lo;
      case (op)
        OP_MOV:  regs[ra] = regs[rb];
        OP_ADD:  regs[ra] = alu_eval(ALU_ADD, regs[rb], regs[rc]);
        OP_SUB:  regs[ra] = alu_eval(ALU_SUB, regs[rb], regs[rc]);
        OP_OR:   regs[ra] = alu_eval(ALU_OR, regs[rb], regs[rc]);
        OP_AND:  regs[ra] = alu_eval(ALU_AND, regs[rb], regs[rc]);
        OP_NOT:  regs[ra] = alu_eval(ALU_NOT, regs[rb], regs[rc]);
        OP_ADDI: regs[ra] = alu_eval(ALU_ADD, regs[rb], imm);
        OP_SUBI: regs[ra] = alu_eval(ALU_SUB, regs[rb], imm);
        OP_ORI:  regs[ra] = alu_eval(ALU_OR, regs[rb], imm);
        OP_ANDI: regs[ra] = alu_eval(ALU_AND, regs[rb], imm);
        OP_SL:   regs[ra] = alu_eval(ALU_SL, regs[rb], regs[rc]);
        OP_SR:   regs[ra] = alu_eval(ALU_SR, regs[rb], regs[rc]);
        OP_SRA:  regs[ra] = alu_eval(ALU_SRA, regs[rb], regs[rc]);
        OP_LDW, OP_STW, OP_LDB, OP_STB: begin
          is_word = (op == OP_LDW || op == OP_STW);
          if (!seg_base(rb, seg) || (is_word && seg == 16'h0)) begin
            halt_code = ST_SEGF;
          end else begin
            ea = (longint'(seg) << 16) + regs[rb] + imm;
            if (ea >= (longint'(1) << ADDR_BITS)) begin
              halt_code = ST_RANGE;
            end else begin
              wi  = (ea >> 1) & WORD_MASK;
              io  = (ea >> 16) == SEG_IO;
              hit = ea == IO_PORT;
              v   = regs[ra];
              if (op == OP_LDW || op == OP_LDB) begin
                if (io) rd = hit ? {8'h0, rx} : 16'h0;
                else if (is_word) rd = mem_rd(wi);
                else rd = ea[0] ? {8'h0, mem_rd(wi) >> 8} : {8'h0, mem_rd(wi) & 16'h00FF};
                res.rxu  = hit;
                regs[ra] = rd;
              end else begin
                if (hit) begin
                  res.txv = 1'b1;
                  res.txb = v[7:0];
                end
                if (is_word) mem_img[wi] = v;
                else if (ea[0]) mem_img[wi] = (mem_rd(wi) & 16'h00FF) | {v[7:0], 8'h00};
                else mem_img[wi] = (mem_rd(wi) & 16'hFF00) | v[7:0];
              end
            end
          end
        end
        OP_JMP: regs[REG_PC] = imm;
        OP_JZ:  if (regs[REG_FL][0]) regs[REG_PC] = imm;
        OP_JC:  if (regs[REG_FL][1]) regs[REG_PC] = imm;
        OP_JNZ: if (!regs[REG_FL][0]) regs[REG_PC] = imm;
        OP_JNC: if (!regs[REG_FL][1]) regs[REG_PC] = imm;
        OP_JAL: begin
          regs[REG_RA] = regs[REG_PC];
          regs[REG_PC] = imm;
        end
        OP_JR:   regs[REG_PC] = regs[ra];
        OP_HALT: halt_code = ST_HALT;
        default: ;
      endcase
    end
    res.status = halt_code;
    res.pc     = regs[REG_PC];
    res.flags  = regs[REG_FL][1:0];
    return res;
  endfunction

  function automatic logic [15:0] enc(input logic [4:0] op, input logic [4:0] a,
                                      input logic [4:0] b);
    return {op, 1'b0, a, b};
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
    n_errors++;
  endtask

  // send one item; a typed expectation replaces the predicted one
  task automatic send(input logic req, input logic [19:0] addr, input logic [15:0] data,
                      input logic [7:0] rx, input bit typed = 0,
                      input core_result_t want = '0);
    int gap;
    core_result_t pred;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_host_word_addr <= addr;
    in_host_word_data <= data;
    in_rx_byte        <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = core_next(req, addr, data, rx);
    pending_q.push_back(typed ? want : pred);
    if (req == KIND_STEP) n_steps++;
    if (pred.txv) n_tx++;
    if (pred.rxu) n_rx++;
  endtask

  // load one instruction at the current pc and run it
  task automatic run_instr(input logic [15:0] hi, input logic [15:0] lo);
    logic [19:0] wa;
    wa = {3'b0, regs[REG_PC], 1'b0};
    send(KIND_HOST, wa, lo, 8'($urandom));
    send(KIND_HOST, wa + 1, hi, 8'($urandom));
    send(KIND_STEP, 20'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // random instruction that keeps the core running
  task automatic random_instr();
    logic [4:0]  op, a, b;
    logic [15:0] lo;
    int          pick;
    bit          is_word;
    logic [4:0]  bases [13] = '{0, 1, 2, 3, 4, 5, 6, 7, 5'd23, REG_SP, REG_DSEG,
                                5'd27, REG_IOB};
    a    = 5'($urandom);
    b    = 5'($urandom);
    lo   = rand_imm();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      op = 5'($urandom_range(OP_MOV, OP_SRA));
    end else if (pick < 62) begin
      case ($urandom_range(0, 3))
        0: op = OP_LDW;
        1: op = OP_STW;
        2: op = OP_LDB;
        default: op = OP_STB;
      endcase
      is_word = (op == OP_LDW || op == OP_STW);
      case ($urandom_range(0, 5))
        0: b = REG_SEGX;
        1: b = REG_BSEG;
        2: b = REG_IOB;
        default: b = bases[$urandom_range(0, 12)];
      endcase
      if (b == REG_BSEG && is_word) b = REG_DSEG;
      if (b == REG_SEGX && (regs[REG_SEGV] > 16'h1E || (is_word && regs[REG_SEGV] == 0)))
        b = REG_IOB;
      if (b == REG_IOB && $urandom_range(0, 1)) lo = 16'h0;
      n_mem++;
    end else if (pick < 77) begin
      op = 5'($urandom_range(OP_JMP, OP_JR));
    end else if (pick < 82) begin
      op = $urandom_range(0, 2) == 0 ? OP_NOP :
           ($urandom_range(0, 1) ? OP_SPARE_A : 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
    end else begin
      // small values for shift amounts, segment r30 and the serial base
      op = OP_ANDI;
      case ($urandom_range(0, 2))
        0: begin a = REG_IOB; b = REG_ZERO; lo = 16'h0; end
        1: begin a = REG_SEGV; lo = 16'($urandom_range(0, 31)); end
        default: lo = 16'($urandom_range(0, 18));
      endcase
    end
    run_instr(enc(op, a, b), lo);
  endtask

  always @(posedge clk) begin
    core_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_run_status !== want.status) report("status", out_run_status, want.status);
        if (out_program_counter !== want.pc) report("pc", out_program_counter, want.pc);
        if (out_flag_bits !== want.flags) report("flags", out_flag_bits, want.flags);
        if (out_tx_valid !== want.txv) report("tx_valid", out_tx_valid, want.txv);
        if (out_tx_byte !== want.txb) report("tx_byte", out_tx_byte, want.txb);
        if (out_rx_used !== want.rxu) report("rx_used", out_rx_used, want.rxu);
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      recv_stall <= recv_burst ? 0 : $urandom_range(0, 13);
    end
  end

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    stim_row_t dir [$];
    stim_row_t row;
    int        wait_cnt;
    int        stop_kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_host_word_addr = '0;
    in_host_word_data = '0;
    in_rx_byte = '0;
    out_ready = 1'b0;
    recv_stall = 0;
    n_errors = 0;
    n_steps = 0;
    n_tx = 0;
    n_rx = 0;
    n_mem = 0;
    send_burst = 0;
    recv_burst = 0;
    foreach (regs[i]) regs[i] = '0;
    regs[REG_SP] = 16'hFFFF;
    halt_code = ST_RUN;

    // directed program at pc 0..5, first row checked against its known result
    row = '{KIND_HOST, 20'hFFFFF, 16'h0000, 8'hFF, 1, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00000, 16'hFFFF, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00001, enc(OP_ADDI, 1, 0), 8'h00, 0, '0};         dir.push_back(row);
    row = '{KIND_STEP, 20'h00000, 16'h0000, 8'hFF, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00002, 16'h0800, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00003, enc(OP_ADD, 2, 1), 8'h00, 0, '0};          dir.push_back(row);
    row = '{KIND_STEP, 20'hFFFFF, 16'hFFFF, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00004, 16'h0000, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00005, enc(OP_STB, 1, REG_IOB), 8'h00, 0, '0};    dir.push_back(row);
    row = '{KIND_STEP, 20'h00000, 16'h0000, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00006, 16'h0000, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00007, enc(OP_LDW, 4, REG_IOB), 8'h00, 0, '0};    dir.push_back(row);
    row = '{KIND_STEP, 20'h00000, 16'h0000, 8'hA5, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00008, 16'hFFFF, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h00009, enc(OP_SUBI, 5, 1), 8'h00, 0, '0};         dir.push_back(row);
    row = '{KIND_STEP, 20'h00000, 16'h0000, 8'h5A, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h0000A, 16'h0003, 8'h00, 0, '0};                   dir.push_back(row);
    row = '{KIND_HOST, 20'h0000B, enc(OP_LDB, 6, REG_BSEG), 8'h00, 0, '0};   dir.push_back(row);
    row = '{KIND_STEP, 20'h00000, 16'h0000, 8'h00, 0, '0};                   dir.push_back(row);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir[i])
      send(dir[i].req, dir[i].addr, dir[i].data, dir[i].rx, dir[i].typed, dir[i].want);

    for (int i = 0; i < N_RANDOM / 3; i++) begin
      if (i == N_RANDOM / 6) begin
        // hold the sender until the core has drained
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
      end
      if ($urandom_range(0, 9) == 0)
        send(KIND_HOST, 20'($urandom), 16'($urandom), 8'($urandom));
      else
        random_instr();
    end

    // end with one way of stopping, then steps that must change nothing
    stop_kind = $urandom_range(0, 2);
    case (stop_kind)
      0: run_instr(enc(OP_HALT, 0, 0), 16'($urandom));
      1: run_instr(enc(OP_LDW, 1, REG_BAD), 16'h0);
      default: begin
        run_instr(enc(OP_ORI, REG_SEGV, REG_ZERO), 16'h00FF);
        run_instr(enc(OP_LDB, 1, REG_SEGX), 16'h0);
      end
    endcase
    send(KIND_STEP, 20'h0, 16'h0, 8'hFF);
    send(KIND_HOST, 20'hFFFFF, 16'hFFFF, 8'h00);
    send(KIND_STEP, 20'h0, 16'h0, 8'hFF);
    @(negedge clk);
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (pending_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_q.size());
      n_errors++;
    end
    $display("ran %0d steps (%0d memory ops, %0d serial sends, %0d serial reads), stop kind %0d",
             n_steps, n_mem, n_tx, n_rx, stop_kind);
    $display("%0d mismatches over %0d cycles", n_errors, cycles);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
